/* hdl/hlspq_pkg.sv */
// Shared types and constants of the head-locked stable priority queue.
// Holds the request and response structs, the stored entry, status codes
// and the control state type. No dependencies.
package hlspq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PRIORITY_BITS = 8;

	localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  new_priority;
		logic [15:0] new_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_priority;
		logic [15:0] out_tag;
		logic [4:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [PRIORITY_BITS-1:0] prio;
		logic [15:0]              tag;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEQ,
		ST_CMP,
		ST_DONE
	} state_t;

endpackage

/* hdl/head_locked_stable_priority_queue_unit.sv */
// Top level of the head-locked stable priority queue.
// Depends on hlspq_pkg for types, status codes and sizing constants.
//
// Usage:
// The request channel (req_valid, req_stall, req) carries one operation:
// an enqueue of a priority and tag, or a dequeue of the head entry. The
// response channel (rsp_valid, rsp_stall, rsp) returns exactly one result
// per request: a status, the dequeued priority and tag (zero otherwise)
// and the occupancy after the operation.
// Entries live in a circular buffer held in one synchronous memory. A
// dequeue from a non-empty queue reads the head entry and then builds its
// result; a dequeue from an empty queue, or an enqueue into a full queue or
// a queue of at most one entry, goes straight to its result. Any other
// enqueue walks back from the tail, one memory read and one write per cycle
// as the memory has one port of each, moving each overtaken entry up a slot.
// One request is in work at a time; req_stall is high from acceptance until
// its result is loaded into the response register, and a stalled receiver
// holds back the next request once the result cannot be handed over.
// Reset empties the queue at once; memory contents need no clearing.
module head_locked_stable_priority_queue_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  hlspq_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output hlspq_pkg::rsp_t   rsp
);

	localparam int AW = hlspq_pkg::ADDR_W;
	localparam int CW = hlspq_pkg::CNT_W;
	localparam int PW = hlspq_pkg::PRIORITY_BITS;

	hlspq_pkg::state_t state_q, state_d;

	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] cur_q, cur_d;
	logic [PW-1:0] new_prio_q, new_prio_d;
	logic [15:0]   new_tag_q, new_tag_d;

	logic [1:0]    res_status_q, res_status_d;
	logic [7:0]    res_prio_q, res_prio_d;
	logic [15:0]   res_tag_q, res_tag_d;

	logic            rsp_valid_q;
	hlspq_pkg::rsp_t rsp_q;

	hlspq_pkg::entry_t mem [hlspq_pkg::QUEUE_DEPTH];
	hlspq_pkg::entry_t rd_q;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	hlspq_pkg::entry_t wr_data;

	logic          accept;
	logic          shift_go;
	logic          rsp_load;
	logic [PW-1:0] prio_in;

	// Maps a position counted from the head to a physical memory slot.
	function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= (CW+1)'(hlspq_pkg::QUEUE_DEPTH)) begin
			s = s - (CW+1)'(hlspq_pkg::QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign req_stall = (state_q != hlspq_pkg::ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign prio_in   = PW'(req.new_priority);
	assign rsp_load  = (state_q == hlspq_pkg::ST_DONE) && (!rsp_valid_q || !rsp_stall);

	// An entry behind the head with lower priority than the new one moves up.
	assign shift_go = (cur_q > CW'(1)) && (rd_q.prio < new_prio_q);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hlspq_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req.opcode == hlspq_pkg::OP_DEQ) begin
						state_d = (count_q == '0) ? hlspq_pkg::ST_DONE : hlspq_pkg::ST_DEQ;
					end else if (count_q == CW'(hlspq_pkg::QUEUE_DEPTH) ||
							count_q <= CW'(1)) begin
						state_d = hlspq_pkg::ST_DONE;
					end else begin
						state_d = hlspq_pkg::ST_CMP;
					end
				end
			end
			hlspq_pkg::ST_DEQ: begin
				state_d = hlspq_pkg::ST_DONE;
			end
			hlspq_pkg::ST_CMP: begin
				if (!shift_go) begin
					state_d = hlspq_pkg::ST_DONE;
				end
			end
			hlspq_pkg::ST_DONE: begin
				if (rsp_load) begin
					state_d = hlspq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hlspq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		head_d       = head_q;
		count_d      = count_q;
		cur_d        = cur_q;
		new_prio_d   = new_prio_q;
		new_tag_d    = new_tag_q;
		res_status_d = res_status_q;
		res_prio_d   = res_prio_q;
		res_tag_d    = res_tag_q;
		rd_en        = 1'b0;
		rd_addr      = head_q;
		wr_en        = 1'b0;
		wr_addr      = head_q;
		wr_data      = '{prio: new_prio_q, tag: new_tag_q};
		case (state_q)
			hlspq_pkg::ST_IDLE: begin
				if (accept) begin
					res_status_d = hlspq_pkg::STATUS_OK;
					res_prio_d   = '0;
					res_tag_d    = '0;
					new_prio_d   = prio_in;
					new_tag_d    = req.new_tag;
					if (req.opcode == hlspq_pkg::OP_DEQ) begin
						if (count_q == '0) begin
							res_status_d = hlspq_pkg::STATUS_EMPTY;
						end else begin
							rd_en   = 1'b1;
							rd_addr = head_q;
						end
					end else if (count_q == CW'(hlspq_pkg::QUEUE_DEPTH)) begin
						res_status_d = hlspq_pkg::STATUS_FULL;
					end else if (count_q <= CW'(1)) begin
						wr_en   = 1'b1;
						wr_addr = slot_addr(head_q, count_q);
						wr_data = '{prio: prio_in, tag: req.new_tag};
						count_d = count_q + CW'(1);
					end else begin
						// Start the backward walk at the tail.
						rd_en   = 1'b1;
						rd_addr = slot_addr(head_q, count_q - CW'(1));
						cur_d   = count_q;
					end
				end
			end
			hlspq_pkg::ST_DEQ: begin
				res_prio_d = 8'(rd_q.prio);
				res_tag_d  = rd_q.tag;
				head_d     = slot_addr(head_q, CW'(1));
				count_d    = count_q - CW'(1);
			end
			hlspq_pkg::ST_CMP: begin
				wr_en   = 1'b1;
				wr_addr = slot_addr(head_q, cur_q);
				if (shift_go) begin
					wr_data = rd_q;
					cur_d   = cur_q - CW'(1);
					// Fetch the next entry toward the head; when that is the head
					// itself, the cursor stop keeps it from being compared.
					rd_en   = 1'b1;
					rd_addr = slot_addr(head_q, cur_q - CW'(2));
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			hlspq_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hlspq_pkg::ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			cur_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			cur_q   <= cur_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		new_prio_q   <= new_prio_d;
		new_tag_q    <= new_tag_d;
		res_status_q <= res_status_d;
		res_prio_q   <= res_prio_d;
		res_tag_q    <= res_tag_d;
		if (rsp_load) begin
			rsp_q.status       <= res_status_q;
			rsp_q.out_priority <= res_prio_q;
			rsp_q.out_tag      <= res_tag_q;
			rsp_q.occupancy    <= 5'(count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(hlspq_pkg::QUEUE_DEPTH))
		else $error("entry count exceeds queue depth");

	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("memory read and write hit the same slot");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hlspq_pkg::ST_CMP) |-> (cur_q != '0 && cur_q <= count_q))
		else $error("insertion cursor outside the queue");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hlspq_pkg::ST_DEQ) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("dequeue did not remove one entry");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != hlspq_pkg::STATUS_OK) |->
		(rsp.out_priority == '0 && rsp.out_tag == '0))
		else $error("error response carries entry data");
`endif

endmodule

/* verif/tb_head_locked_stable_priority_queue_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for head_locked_stable_priority_queue_unit.
// Drives a directed table, then random enqueue/dequeue traffic; checks every response
// against a local queue model or the table's expected one. Needs hlspq_pkg and the RTL.
module tb_head_locked_stable_priority_queue_unit;
	import hlspq_pkg::*;

	localparam int TOTAL_ITEMS      = 1450;
	localparam int DIRECTED_ROWS    = 23;
	localparam int HOLD_AT_ITEM     = 400;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int CALM_TAIL        = 150;
	localparam int DRAIN_CYCLES     = 40;
	localparam int WATCHDOG_LIMIT   = 2000;

	typedef struct {
		req_t request;
		bit   has_want;
		rsp_t want;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	entry_t        model_entries [QUEUE_DEPTH];
	int            model_count;
	rsp_t          pending_responses [$];
	directed_row_t directed_rows [DIRECTED_ROWS];
	int            error_count;
	int            quiet_cycles;
	bit            idle_on;
	bit            long_hold_request;
	bit            stimulus_done;

	head_locked_stable_priority_queue_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		error_count       = 0;
		quiet_cycles      = 0;
		model_count       = 0;
		idle_on           = 1'b1;
		long_hold_request = 1'b0;
		stimulus_done     = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Applies one request to the local queue and returns the response it should give.
	function automatic rsp_t next_queue_response(req_t r);
		rsp_t   res;
		entry_t fresh;
		int     pos;
		res = '0;
		if (r.opcode == OP_DEQ) begin
			if (model_count == 0) begin
				res.status = STATUS_EMPTY;
			end else begin
				res.status       = STATUS_OK;
				res.out_priority = model_entries[0].prio;
				res.out_tag      = model_entries[0].tag;
				for (int i = 1; i < model_count; i++)
					model_entries[i-1] = model_entries[i];
				model_count--;
			end
		end else if (model_count >= QUEUE_DEPTH) begin
			res.status = STATUS_FULL;
		end else begin
			fresh.prio = r.new_priority[PRIORITY_BITS-1:0];
			fresh.tag  = r.new_tag;
			pos = model_count;
			// The head is in service: a higher priority only overtakes entries behind it,
			// and stops behind every entry of equal priority.
			if (model_count > 1 && fresh.prio > model_entries[model_count-1].prio) begin
				pos = 1;
				while (pos < model_count && model_entries[pos].prio >= fresh.prio)
					pos++;
			end
			for (int i = model_count; i > pos; i--)
				model_entries[i] = model_entries[i-1];
			model_entries[pos] = fresh;
			model_count++;
			res.status = STATUS_OK;
		end
		res.occupancy = 5'(model_count);
		return res;
	endfunction

	initial begin : request_driver
		req_t item;
		rsp_t expected;
		bit   filling;
		filling = 1'b1;
		req_valid <= 1'b0;
		req       <= '0;

		directed_rows[0]  = '{'{OP_DEQ, 8'h00, 16'h0000}, 1'b1, '{STATUS_EMPTY, 8'h00, 16'h0000, 5'd0}};
		directed_rows[1]  = '{'{OP_ENQ, 8'h00, 16'h0000}, 1'b1, '{STATUS_OK, 8'h00, 16'h0000, 5'd1}};
		directed_rows[2]  = '{'{OP_ENQ, 8'hFF, 16'hFFFF}, 1'b1, '{STATUS_OK, 8'h00, 16'h0000, 5'd2}};
		directed_rows[3]  = '{'{OP_ENQ, 8'h80, 16'h1234}, 1'b0, '0};
		directed_rows[4]  = '{'{OP_ENQ, 8'hC8, 16'h2001}, 1'b0, '0};
		directed_rows[5]  = '{'{OP_ENQ, 8'hC8, 16'h2002}, 1'b0, '0};
		directed_rows[6]  = '{'{OP_ENQ, 8'hFF, 16'h2003}, 1'b0, '0};
		directed_rows[7]  = '{'{OP_ENQ, 8'h01, 16'h2004}, 1'b0, '0};
		// The lowest entry went in first, so it is in service and leaves first.
		directed_rows[8]  = '{'{OP_DEQ, 8'hFF, 16'hFFFF}, 1'b1, '{STATUS_OK, 8'h00, 16'h0000, 5'd6}};
		for (int k = 0; k < 10; k++)
			directed_rows[9+k] = '{'{OP_ENQ, 8'(k * 37), 16'hA5A0 + 16'(k)}, 1'b0, '0};
		directed_rows[19] = '{'{OP_ENQ, 8'hFF, 16'hFFFF}, 1'b1, '{STATUS_FULL, 8'h00, 16'h0000, 5'd16}};
		directed_rows[20] = '{'{OP_ENQ, 8'h00, 16'h0000}, 1'b1, '{STATUS_FULL, 8'h00, 16'h0000, 5'd16}};
		directed_rows[21] = '{'{OP_DEQ, 8'h00, 16'h0000}, 1'b0, '0};
		directed_rows[22] = '{'{OP_DEQ, 8'h00, 16'h0000}, 1'b0, '0};

		wait (arst_n === 1'b1);
		@(posedge clk);
		for (int n = 0; n < TOTAL_ITEMS; n++) begin
			if (n < DIRECTED_ROWS) begin
				item = directed_rows[n].request;
			end else begin
				// Swing between filling and draining so both full and empty are hit often.
				if (model_count == QUEUE_DEPTH)
					filling = 1'b0;
				else if (model_count == 0)
					filling = 1'b1;
				else if ($urandom_range(0, 39) == 0)
					filling = !filling;
				item.opcode = ($urandom_range(0, 99) < 75) == filling ? OP_ENQ : OP_DEQ;
				case ($urandom_range(0, 3))
					0: item.new_priority = 8'($urandom_range(0, 3));
					1: item.new_priority = 8'($urandom_range(252, 255));
					default: item.new_priority = 8'($urandom_range(0, 255));
				endcase
				item.new_tag = 16'($urandom_range(0, 65535));
			end
			if (n % 100 == 0)
				idle_on = $urandom_range(0, 2) != 0;
			if (n == HOLD_AT_ITEM) begin
				long_hold_request = 1'b1;
				idle_on = 1'b0;
			end
			if (n >= TOTAL_ITEMS - CALM_TAIL)
				idle_on = 1'b0;
			if (idle_on && $urandom_range(0, 7) == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			req_valid <= 1'b1;
			req       <= item;
			@(posedge clk);
			while (req_stall) @(posedge clk);
			expected = next_queue_response(item);
			if (n < DIRECTED_ROWS && directed_rows[n].has_want)
				expected = directed_rows[n].want;
			pending_responses.push_back(expected);
		end
		req_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	initial begin : response_receiver
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_request) begin
				// Hold off long enough that the unit backs up and stalls new requests.
				long_hold_request = 1'b0;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : response_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_responses.size() == 0) begin
				$error("response with no request outstanding: %p", rsp);
				error_count++;
			end else begin
				want = pending_responses.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					error_count++;
				end
				if (rsp.out_priority !== want.out_priority) begin
					$error("out_priority: expected %0d, actual %0d",
						want.out_priority, rsp.out_priority);
					error_count++;
				end
				if (rsp.out_tag !== want.out_tag) begin
					$error("out_tag: expected 0x%04h, actual 0x%04h", want.out_tag, rsp.out_tag);
					error_count++;
				end
				if (rsp.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, actual %0d", want.occupancy, rsp.occupancy);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$error("no request or response moved for %0d cycles", WATCHDOG_LIMIT);
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	initial begin : run_end
		wait (stimulus_done);
		while (pending_responses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
hdl/hlspq_pkg.sv
hdl/head_locked_stable_priority_queue_unit.sv
verif/tb_head_locked_stable_priority_queue_unit.sv
